### src/tps_pkg.sv
// ============================================================================
// tps_pkg - triangle plane slicer shared definitions
// Widths, register indexes and the edge record passed from front to back.
// ============================================================================
package tps_pkg;

    localparam int INDEX_BITS_DEF = 20;
    localparam int COORD_W   = 32;
    localparam int NORM_W    = 18;
    localparam int PROD_W    = NORM_W + COORD_W;      // normal * coordinate
    localparam int DIST_W    = 52;                    // plane distance, |s| < 2^51
    localparam int SPLIT_W   = 26;                    // low slice of a distance
    localparam int PART_W    = SPLIT_W + 1 + COORD_W; // slice * coordinate
    localparam int NUM_W     = 85;                    // cross-multiplied numerator
    localparam int MAG_W     = NUM_W - 1;
    localparam int DEN_W     = DIST_W + 1;            // distance difference
    localparam int DMAG_W    = DEN_W - 1;
    localparam int QUO_W     = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_IDX_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NORMAL_X       = 8'd0,
        REG_NORMAL_Y       = 8'd1,
        REG_NORMAL_Z       = 8'd2,
        REG_PLANE_DISTANCE = 8'd3
    } t_reg_idx;

    typedef struct packed {
        logic signed [NORM_W-1:0]  nx;
        logic signed [NORM_W-1:0]  ny;
        logic signed [NORM_W-1:0]  nz;
        logic signed [COORD_W-1:0] offset;
    } t_plane;

    // classified triangle: distances and positions of the from-edge ends
    typedef struct packed {
        logic                          crosses;
        logic [DIST_W-1:0]             s_lo;
        logic [DIST_W-1:0]             s_hi;
        logic [2:0][COORD_W-1:0]       v_lo;
        logic [2:0][COORD_W-1:0]       v_hi;
    } t_edge;

endpackage

### src/tps_if.sv
// ============================================================================
// tps_if - triangle plane slicer channels
// Triangle input, slice result and configuration write channels.
// ============================================================================
interface tps_tri_if #(parameter int INDEX_BITS = tps_pkg::INDEX_BITS_DEF);
    logic                  valid;
    logic                  ready;
    logic [INDEX_BITS-1:0] index_a;
    logic [INDEX_BITS-1:0] index_b;
    logic [INDEX_BITS-1:0] index_c;
    logic signed [31:0]    a_x, a_y, a_z;
    logic signed [31:0]    b_x, b_y, b_z;
    logic signed [31:0]    c_x, c_y, c_z;
    modport source(output valid, index_a, index_b, index_c, a_x, a_y, a_z,
                   b_x, b_y, b_z, c_x, c_y, c_z, input ready);
    modport sink(input valid, index_a, index_b, index_c, a_x, a_y, a_z,
                 b_x, b_y, b_z, c_x, c_y, c_z, output ready);
endinterface

interface tps_res_if #(parameter int INDEX_BITS = tps_pkg::INDEX_BITS_DEF);
    logic                  valid;
    logic                  ready;
    logic                  crosses;
    logic [INDEX_BITS-1:0] from_low_index;
    logic [INDEX_BITS-1:0] from_high_index;
    logic [INDEX_BITS-1:0] to_low_index;
    logic [INDEX_BITS-1:0] to_high_index;
    logic signed [31:0]    point_x, point_y, point_z;
    modport source(output valid, crosses, from_low_index, from_high_index,
                   to_low_index, to_high_index, point_x, point_y, point_z, input ready);
    modport sink(input valid, crosses, from_low_index, from_high_index,
                 to_low_index, to_high_index, point_x, point_y, point_z, output ready);
endinterface

interface tps_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [tps_pkg::CFG_IDX_W-1:0]      index;
    logic [31:0]                        data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

### src/tps_front.sv
// ============================================================================
// tps_front - plane distances and crossing classification
// Three stages: products, distance sums, lone-vertex edge selection.
// ============================================================================
module tps_front #(
    parameter int INDEX_BITS = tps_pkg::INDEX_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tps_tri_if.sink               i_tri,
    input  tps_pkg::t_plane       i_plane,
    output logic                  o_valid,
    input  logic                  i_ready,
    output tps_pkg::t_edge        o_edge,
    output logic [INDEX_BITS-1:0] o_idx [4]
);
    localparam int PW = tps_pkg::PROD_W;
    localparam int DW = tps_pkg::DIST_W;

    logic en;
    logic signed [31:0] in_pos [3][3];
    logic [INDEX_BITS-1:0] in_idx [3];

    logic                   r_s1_v;
    logic [INDEX_BITS-1:0]  r_s1_idx [3];
    logic signed [31:0]     r_s1_pos [3][3];
    logic signed [PW-1:0]   r_s1_prod [3][3];
    logic signed [DW-1:0]   r_s1_off;

    logic                   r_s2_v;
    logic [INDEX_BITS-1:0]  r_s2_idx [3];
    logic signed [31:0]     r_s2_pos [3][3];
    logic signed [DW-1:0]   r_s2_s [3];

    logic                   r_s3_v;
    tps_pkg::t_edge         r_s3_edge;
    logic [INDEX_BITS-1:0]  r_s3_idx [4];

    logic [2:0] up;
    logic       dup, crossing;
    logic [1:0] lone, fs, ts, lo, hi;
    tps_pkg::t_edge n_edge;
    logic [INDEX_BITS-1:0] n_idx [4];

    assign en          = !r_s3_v || i_ready;
    assign i_tri.ready = en;
    assign o_valid     = r_s3_v;
    assign o_edge      = r_s3_edge;
    assign o_idx       = r_s3_idx;

    assign in_idx = '{i_tri.index_a, i_tri.index_b, i_tri.index_c};
    assign in_pos = '{'{i_tri.a_x, i_tri.a_y, i_tri.a_z},
                      '{i_tri.b_x, i_tri.b_y, i_tri.b_z},
                      '{i_tri.c_x, i_tri.c_y, i_tri.c_z}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= i_tri.valid;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_s1_idx[k]     <= in_idx[k];
                r_s1_pos[k]     <= in_pos[k];
                r_s1_prod[k][0] <= PW'(i_plane.nx * in_pos[k][0]);
                r_s1_prod[k][1] <= PW'(i_plane.ny * in_pos[k][1]);
                r_s1_prod[k][2] <= PW'(i_plane.nz * in_pos[k][2]);
            end
            r_s1_off <= DW'(i_plane.offset) <<< 16;
            for (int k = 0; k < 3; k++) begin
                r_s2_idx[k] <= r_s1_idx[k];
                r_s2_pos[k] <= r_s1_pos[k];
                r_s2_s[k]   <= DW'(r_s1_prod[k][0]) + DW'(r_s1_prod[k][1])
                             + DW'(r_s1_prod[k][2]) - r_s1_off;
            end
            r_s3_edge <= n_edge;
            r_s3_idx  <= n_idx;
        end
    end

    // lone vertex and oriented edges
    always_comb begin
        for (int k = 0; k < 3; k++) up[k] = !r_s2_s[k][DW-1];
        dup      = (r_s2_idx[0] == r_s2_idx[1]) || (r_s2_idx[0] == r_s2_idx[2])
                || (r_s2_idx[1] == r_s2_idx[2]);
        crossing = !dup && !(up[0] == up[1] && up[1] == up[2]);
        if (up[1] == up[2])      lone = 2'd0;
        else if (up[0] == up[2]) lone = 2'd1;
        else                     lone = 2'd2;
        case ({lone, up[lone]})
            3'b001:  begin fs = 2'd1; ts = 2'd2; end
            3'b000:  begin fs = 2'd2; ts = 2'd1; end
            3'b011:  begin fs = 2'd2; ts = 2'd0; end
            3'b010:  begin fs = 2'd0; ts = 2'd2; end
            3'b101:  begin fs = 2'd0; ts = 2'd1; end
            default: begin fs = 2'd1; ts = 2'd0; end
        endcase
        if (r_s2_idx[fs] < r_s2_idx[lone]) begin
            lo = fs;
            hi = lone;
        end else begin
            lo = lone;
            hi = fs;
        end
        n_edge.crosses = crossing;
        n_edge.s_lo    = r_s2_s[lo];
        n_edge.s_hi    = r_s2_s[hi];
        for (int j = 0; j < 3; j++) begin
            n_edge.v_lo[j] = r_s2_pos[lo][j];
            n_edge.v_hi[j] = r_s2_pos[hi][j];
        end
        n_idx[0] = r_s2_idx[lo];
        n_idx[1] = r_s2_idx[hi];
        if (r_s2_idx[ts] < r_s2_idx[lone]) begin
            n_idx[2] = r_s2_idx[ts];
            n_idx[3] = r_s2_idx[lone];
        end else begin
            n_idx[2] = r_s2_idx[lone];
            n_idx[3] = r_s2_idx[ts];
        end
        if (!crossing) begin
            for (int k = 0; k < 4; k++) n_idx[k] = '0;
        end
    end

endmodule

### src/tps_queue.sv
// ============================================================================
// tps_queue - classified triangle queue
// Small flop FIFO between the classifier and the crossing-point pipeline.
// ============================================================================
module tps_queue #(
    parameter int INDEX_BITS = tps_pkg::INDEX_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  tps_pkg::t_edge        i_edge,
    input  logic [INDEX_BITS-1:0] i_idx [4],
    output logic                  o_valid,
    input  logic                  i_ready,
    output tps_pkg::t_edge        o_edge,
    output logic [INDEX_BITS-1:0] o_idx [4]
);
    localparam int DEPTH = tps_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tps_pkg::t_edge        r_edge [DEPTH];
    logic [INDEX_BITS-1:0] r_idx  [DEPTH][4];
    logic [PTR_W-1:0]      r_wp, r_rp;
    logic [CNT_W-1:0]      r_cnt;
    logic push, pop;

    assign o_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_edge  = r_edge[r_rp];
    assign o_idx   = r_idx[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (pop)  r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + CNT_W'(push) - CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_edge[r_wp] <= i_edge;
            r_idx[r_wp]  <= i_idx;
        end
    end

endmodule

### src/tps_back.sv
// ============================================================================
// tps_back - crossing point pipeline
// Split multiplies, numerator and divisor, one quotient bit per stage.
// ============================================================================
module tps_back #(
    parameter int INDEX_BITS = tps_pkg::INDEX_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  tps_pkg::t_edge        i_edge,
    input  logic [INDEX_BITS-1:0] i_idx [4],
    tps_res_if.source             o_res
);
    localparam int SW  = tps_pkg::SPLIT_W;
    localparam int DW  = tps_pkg::DIST_W;
    localparam int PTW = tps_pkg::PART_W;
    localparam int NW  = tps_pkg::NUM_W;
    localparam int MW  = tps_pkg::MAG_W;
    localparam int EW  = tps_pkg::DEN_W;
    localparam int DMW = tps_pkg::DMAG_W;
    localparam int QW  = tps_pkg::QUO_W;

    logic en;

    // multiply stage
    logic                   r_s1_v, r_s1_cr;
    logic [INDEX_BITS-1:0]  r_s1_idx [4];
    logic signed [PTW-1:0]  r_s1_p [3][4];
    logic signed [EW-1:0]   r_s1_d;
    // combine stage
    logic                   r_s2_v, r_s2_cr;
    logic [INDEX_BITS-1:0]  r_s2_idx [4];
    logic signed [NW-1:0]   r_s2_t1 [3], r_s2_t2 [3];
    logic signed [EW-1:0]   r_s2_d;
    // divider stages, index 0 holds the magnitudes
    logic                   r_dv  [QW+1];
    logic                   r_dcr [QW+1];
    logic [INDEX_BITS-1:0]  r_didx [QW+1][4];
    logic [DMW-1:0]         r_den [QW+1];
    logic [MW-1:0]          r_rem [QW+1][3];
    logic [QW-1:0]          r_quo [QW+1][3];
    logic                   r_neg [QW+1][3];
    // output
    logic                   r_ov, r_ocr;
    logic [INDEX_BITS-1:0]  r_oidx [4];
    logic [QW-1:0]          r_opt [3];

    logic signed [SW-1:0] hi_hi, hi_lo;
    logic signed [SW:0]   lo_hi, lo_lo;
    logic signed [NW-1:0] num [3];
    logic signed [EW-1:0] den_s;

    assign en      = !r_ov || o_res.ready;
    assign o_ready = en;

    assign hi_hi = i_edge.s_hi[DW-1:SW];
    assign lo_hi = {1'b0, i_edge.s_hi[SW-1:0]};
    assign hi_lo = i_edge.s_lo[DW-1:SW];
    assign lo_lo = {1'b0, i_edge.s_lo[SW-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_ov   <= 1'b0;
            for (int i = 0; i <= QW; i++) r_dv[i] <= 1'b0;
        end else if (en) begin
            r_s1_v  <= i_valid;
            r_s2_v  <= r_s1_v;
            r_dv[0] <= r_s2_v;
            for (int i = 0; i < QW; i++) r_dv[i+1] <= r_dv[i];
            r_ov    <= r_dv[QW];
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) num[j] = r_s2_t1[j] - r_s2_t2[j];
    end
    assign den_s = r_s2_d;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_cr  <= i_edge.crosses;
            r_s1_idx <= i_idx;
            r_s1_d   <= EW'($signed(i_edge.s_hi)) - EW'($signed(i_edge.s_lo));
            for (int j = 0; j < 3; j++) begin
                r_s1_p[j][0] <= PTW'(hi_hi * $signed(i_edge.v_lo[j]));
                r_s1_p[j][1] <= PTW'(lo_hi * $signed(i_edge.v_lo[j]));
                r_s1_p[j][2] <= PTW'(hi_lo * $signed(i_edge.v_hi[j]));
                r_s1_p[j][3] <= PTW'(lo_lo * $signed(i_edge.v_hi[j]));
            end

            r_s2_cr  <= r_s1_cr;
            r_s2_idx <= r_s1_idx;
            r_s2_d   <= r_s1_d;
            for (int j = 0; j < 3; j++) begin
                r_s2_t1[j] <= (NW'(r_s1_p[j][0]) <<< SW) + NW'(r_s1_p[j][1]);
                r_s2_t2[j] <= (NW'(r_s1_p[j][2]) <<< SW) + NW'(r_s1_p[j][3]);
            end

            r_dcr[0]  <= r_s2_cr;
            r_didx[0] <= r_s2_idx;
            r_den[0]  <= den_s[EW-1] ? DMW'(-den_s) : DMW'(den_s);
            for (int j = 0; j < 3; j++) begin
                r_rem[0][j] <= num[j][NW-1] ? MW'(-num[j]) : MW'(num[j]);
                r_quo[0][j] <= '0;
                r_neg[0][j] <= num[j][NW-1] ^ den_s[EW-1];
            end

            r_ocr  <= r_dcr[QW];
            r_oidx <= r_didx[QW];
            for (int j = 0; j < 3; j++) begin
                if (!r_dcr[QW])          r_opt[j] <= '0;
                else if (r_neg[QW][j])   r_opt[j] <= -r_quo[QW][j];
                else                     r_opt[j] <= r_quo[QW][j];
            end
        end
    end

    // restoring divider, quotient bit QW-1-i resolved in stage i
    for (genvar i = 0; i < QW; i++) begin : g_div
        localparam int SH = QW - 1 - i;
        logic [MW:0] trial [3];
        always_comb begin
            for (int j = 0; j < 3; j++)
                trial[j] = {1'b0, r_rem[i][j]} - ((MW+1)'(r_den[i]) << SH);
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dcr[i+1]  <= r_dcr[i];
                r_didx[i+1] <= r_didx[i];
                r_den[i+1]  <= r_den[i];
                for (int j = 0; j < 3; j++) begin
                    r_neg[i+1][j] <= r_neg[i][j];
                    if (!trial[j][MW]) begin
                        r_rem[i+1][j]     <= trial[j][MW-1:0];
                        r_quo[i+1][j]     <= r_quo[i][j] | (QW'(1) << SH);
                    end else begin
                        r_rem[i+1][j]     <= r_rem[i][j];
                        r_quo[i+1][j]     <= r_quo[i][j];
                    end
                end
            end
        end
    end

    assign o_res.valid           = r_ov;
    assign o_res.crosses         = r_ocr;
    assign o_res.from_low_index  = r_oidx[0];
    assign o_res.from_high_index = r_oidx[1];
    assign o_res.to_low_index    = r_oidx[2];
    assign o_res.to_high_index   = r_oidx[3];
    assign o_res.point_x         = r_opt[0];
    assign o_res.point_y         = r_opt[1];
    assign o_res.point_z         = r_opt[2];

endmodule

### src/triangle_plane_slicer.sv
// ============================================================================
// triangle_plane_slicer - triangle against plane slicer
// Classifies triangles against a plane and returns crossing edges and point.
// ============================================================================
// One triangle per cycle is accepted while the result receiver does not stall the
// pipeline, and one result per triangle is returned, in order. The path runs
// through the classifier, the queue and the crossing-point pipeline (multiply
// stage, combine stage, magnitude stage, 32 restoring-divider stages, output
// register). Configuration writes are always accepted and take effect for
// triangles accepted afterwards.
module triangle_plane_slicer #(
    parameter int INDEX_BITS = tps_pkg::INDEX_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tps_tri_if.sink     i_tri,
    tps_cfg_if.sink     i_cfg,
    tps_res_if.source   o_res
);
    tps_pkg::t_plane r_plane;

    logic                  f_valid, f_ready, q_valid, q_ready;
    tps_pkg::t_edge        f_edge, q_edge;
    logic [INDEX_BITS-1:0] f_idx [4];
    logic [INDEX_BITS-1:0] q_idx [4];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane.nx     <= '0;
            r_plane.ny     <= '0;
            r_plane.nz     <= tps_pkg::NORM_W'(65536);
            r_plane.offset <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                tps_pkg::REG_NORMAL_X:       r_plane.nx <= i_cfg.data[tps_pkg::NORM_W-1:0];
                tps_pkg::REG_NORMAL_Y:       r_plane.ny <= i_cfg.data[tps_pkg::NORM_W-1:0];
                tps_pkg::REG_NORMAL_Z:       r_plane.nz <= i_cfg.data[tps_pkg::NORM_W-1:0];
                tps_pkg::REG_PLANE_DISTANCE: r_plane.offset <= i_cfg.data;
                default: ;
            endcase
        end
    end

    tps_front #(.INDEX_BITS(INDEX_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tri   (i_tri),
        .i_plane (r_plane),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_edge  (f_edge),
        .o_idx   (f_idx)
    );

    tps_queue #(.INDEX_BITS(INDEX_BITS)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_edge  (f_edge),
        .i_idx   (f_idx),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_edge  (q_edge),
        .o_idx   (q_idx)
    );

    tps_back #(.INDEX_BITS(INDEX_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_edge  (q_edge),
        .i_idx   (q_idx),
        .o_res   (o_res)
    );

endmodule

### verif/triangle_plane_slicer_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// triangle_plane_slicer_checker - slice result scoreboard
// Watches the triangle, configuration and result channels, computes the
// expected slice for every accepted triangle and compares results in order.
// ============================================================================
module triangle_plane_slicer_checker #(
    parameter int INDEX_BITS = tps_pkg::INDEX_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tps_tri_if.sink   i_tri,
    tps_cfg_if.sink   i_cfg,
    tps_res_if.sink   i_res,
    output int        o_errors,
    output int        o_pending
);

    typedef struct {
        logic                  crosses;
        logic [INDEX_BITS-1:0] from_lo;
        logic [INDEX_BITS-1:0] from_hi;
        logic [INDEX_BITS-1:0] to_lo;
        logic [INDEX_BITS-1:0] to_hi;
        logic [31:0]           pt [3];
    } t_slice;

    t_slice          slice_q[$];
    tps_pkg::t_plane plane;
    int              errors;
    int              pending;

    assign o_errors  = errors;
    assign o_pending = pending;

    function automatic logic [31:0] crossing_coord(input logic signed [63:0] s_lo,
                                                   input logic signed [63:0] s_hi,
                                                   input logic signed [31:0] v_lo,
                                                   input logic signed [31:0] v_hi);
        logic signed [127:0] num;
        logic signed [127:0] den;
        logic signed [127:0] q;
        num = 128'(s_hi) * 128'(v_lo) - 128'(s_lo) * 128'(v_hi);
        den = 128'(s_hi) - 128'(s_lo);
        q = num / den;  // truncates toward zero
        if (q > 128'sd2147483647) return 32'h7fff_ffff;
        if (q < -128'sd2147483648) return 32'h8000_0000;
        return q[31:0];
    endfunction

    function automatic t_slice slice_triangle(input logic [INDEX_BITS-1:0] idx [3],
                                              input logic signed [31:0] pos [3][3]);
        t_slice r;
        logic signed [63:0] s_val [3];
        logic up [3];
        int lone, f, t, lo, hi;
        r.crosses = 0;
        r.from_lo = '0;
        r.from_hi = '0;
        r.to_lo   = '0;
        r.to_hi   = '0;
        for (int j = 0; j < 3; j++) r.pt[j] = '0;
        for (int k = 0; k < 3; k++) begin
            s_val[k] = 64'(plane.nx) * 64'(pos[k][0]) + 64'(plane.ny) * 64'(pos[k][1])
                     + 64'(plane.nz) * 64'(pos[k][2]) - 64'(plane.offset) * 64'sd65536;
            up[k] = s_val[k] >= 0;
        end
        if (idx[0] == idx[1] || idx[0] == idx[2] || idx[1] == idx[2]) return r;
        if (up[0] == up[1] && up[1] == up[2]) return r;
        lone = (up[1] == up[2]) ? 0 : (up[0] == up[2]) ? 1 : 2;
        // from-edge takes the slot after the lone one when it is up
        case (lone)
            0: begin f = up[0] ? 1 : 2; t = up[0] ? 2 : 1; end
            1: begin f = up[1] ? 2 : 0; t = up[1] ? 0 : 2; end
            default: begin f = up[2] ? 0 : 1; t = up[2] ? 1 : 0; end
        endcase
        r.crosses = 1;
        if (idx[f] < idx[lone]) begin lo = f; hi = lone; end
        else begin lo = lone; hi = f; end
        r.from_lo = idx[lo];
        r.from_hi = idx[hi];
        r.to_lo = (idx[t] < idx[lone]) ? idx[t] : idx[lone];
        r.to_hi = (idx[t] < idx[lone]) ? idx[lone] : idx[t];
        for (int j = 0; j < 3; j++)
            r.pt[j] = crossing_coord(s_val[lo], s_val[hi], pos[lo][j], pos[hi][j]);
        return r;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        logic [INDEX_BITS-1:0] idx [3];
        logic signed [31:0] pos [3][3];
        t_slice want;
        if (!i_rst_n) begin
            plane.nx <= 18'sd0;
            plane.ny <= 18'sd0;
            plane.nz <= 18'sd65536;
            plane.offset <= '0;
            errors = 0;
            slice_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    tps_pkg::REG_NORMAL_X:       plane.nx <= i_cfg.data[tps_pkg::NORM_W-1:0];
                    tps_pkg::REG_NORMAL_Y:       plane.ny <= i_cfg.data[tps_pkg::NORM_W-1:0];
                    tps_pkg::REG_NORMAL_Z:       plane.nz <= i_cfg.data[tps_pkg::NORM_W-1:0];
                    tps_pkg::REG_PLANE_DISTANCE: plane.offset <= i_cfg.data;
                    default: ;
                endcase
            end
            if (i_tri.valid && i_tri.ready) begin
                idx = '{i_tri.index_a, i_tri.index_b, i_tri.index_c};
                pos = '{'{i_tri.a_x, i_tri.a_y, i_tri.a_z},
                        '{i_tri.b_x, i_tri.b_y, i_tri.b_z},
                        '{i_tri.c_x, i_tri.c_y, i_tri.c_z}};
                slice_q.insert(slice_q.size(), slice_triangle(idx, pos));
            end
            if (i_res.valid && i_res.ready) begin
                if (slice_q.size() == 0) begin
                    report("unexpected result", 0, 0);
                end else begin
                    want = slice_q.pop_front();
                    if (i_res.crosses !== want.crosses)
                        report("crosses", i_res.crosses, want.crosses);
                    if (i_res.from_low_index !== want.from_lo)
                        report("from_low_index", i_res.from_low_index, want.from_lo);
                    if (i_res.from_high_index !== want.from_hi)
                        report("from_high_index", i_res.from_high_index, want.from_hi);
                    if (i_res.to_low_index !== want.to_lo)
                        report("to_low_index", i_res.to_low_index, want.to_lo);
                    if (i_res.to_high_index !== want.to_hi)
                        report("to_high_index", i_res.to_high_index, want.to_hi);
                    if (i_res.point_x !== want.pt[0]) report("point_x", i_res.point_x, want.pt[0]);
                    if (i_res.point_y !== want.pt[1]) report("point_y", i_res.point_y, want.pt[1]);
                    if (i_res.point_z !== want.pt[2]) report("point_z", i_res.point_z, want.pt[2]);
                end
            end
        end
        pending = slice_q.size();
    end

endmodule

### verif/triangle_plane_slicer_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// triangle_plane_slicer_tb - triangle plane slicer regression
// Streams directed and random triangles under several plane settings with
// random idling on both channels; the checker scores every slice result.
// ============================================================================
module triangle_plane_slicer_tb;

    localparam int IB = tps_pkg::INDEX_BITS_DEF;
    localparam int CYCLE_LIMIT = 400000;

    logic i_clk;
    logic i_rst_n;
    int   errors;
    int   pending;
    int   cycles;
    bit   src_busy_free;   // sender never idles
    bit   snk_busy_free;   // receiver never stalls
    bit   snk_hold;        // long receiver hold-off

    tps_tri_if #(.INDEX_BITS(IB)) tri_ch();
    tps_res_if #(.INDEX_BITS(IB)) res_ch();
    tps_cfg_if                    cfg_ch();

    triangle_plane_slicer #(.INDEX_BITS(IB)) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_tri  (tri_ch.sink),
        .i_cfg  (cfg_ch.sink),
        .o_res  (res_ch.source)
    );

    triangle_plane_slicer_checker #(.INDEX_BITS(IB)) u_checker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tri    (tri_ch.sink),
        .i_cfg    (cfg_ch.sink),
        .i_res    (res_ch.sink),
        .o_errors (errors),
        .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("triangle_plane_slicer regression: fail");
            $finish;
        end
    end

    // receiver side
    always @(posedge i_clk) begin
        if (!i_rst_n || snk_hold) res_ch.ready <= 1'b0;
        else res_ch.ready <= snk_busy_free || ($urandom_range(99) >= 38);
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(4))
            0: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
            1: return 32'($signed($urandom_range(2000000)) - 1000000);
            default: return $urandom;
        endcase
    endfunction

    // ready is stable by the falling edge, so it tells whether the next
    // rising edge accepts the transaction
    task automatic send_tri(input logic [IB-1:0] ia, ib, ic,
                            input logic [31:0] p [9]);
        if (!src_busy_free)
            while ($urandom_range(99) < 38) begin
                tri_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        tri_ch.valid   <= 1'b1;
        tri_ch.index_a <= ia;
        tri_ch.index_b <= ib;
        tri_ch.index_c <= ic;
        {tri_ch.a_x, tri_ch.a_y, tri_ch.a_z} <= {p[0], p[1], p[2]};
        {tri_ch.b_x, tri_ch.b_y, tri_ch.b_z} <= {p[3], p[4], p[5]};
        {tri_ch.c_x, tri_ch.c_y, tri_ch.c_z} <= {p[6], p[7], p[8]};
        @(negedge i_clk);
        while (!tri_ch.ready) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic send_random_tri();
        logic [IB-1:0] ia, ib, ic;
        logic [31:0] p [9];
        ia = IB'($urandom);
        ib = IB'($urandom);
        ic = IB'($urandom);
        if ($urandom_range(9) == 0) ib = ia;
        else if ($urandom_range(9) == 0) ic = ib;
        else if ($urandom_range(3) == 0) begin
            // small indices make equal-ordering corners likely
            ia = IB'($urandom_range(3));
            ib = IB'($urandom_range(3));
            ic = IB'($urandom_range(3));
        end
        for (int k = 0; k < 9; k++) p[k] = rand_coord();
        send_tri(ia, ib, ic, p);
    endtask

    // leaves valid high; the caller drops it after the last write
    task automatic write_reg(input tps_pkg::t_reg_idx r, input logic [31:0] d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= r;
        cfg_ch.data  <= d;
        @(negedge i_clk);
        while (!cfg_ch.ready) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic drain();
        tri_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (45) @(posedge i_clk);
    endtask

    task automatic set_plane(input logic [31:0] nx, ny, nz, d);
        write_reg(tps_pkg::REG_NORMAL_X, nx);
        write_reg(tps_pkg::REG_NORMAL_Y, ny);
        write_reg(tps_pkg::REG_NORMAL_Z, nz);
        write_reg(tps_pkg::REG_PLANE_DISTANCE, d);
    endtask

    initial begin
        logic [31:0] p [9];
        snk_hold = 0;
        snk_busy_free = 0;
        src_busy_free = 0;
        i_rst_n = 0;
        tri_ch.valid = 0;
        tri_ch.index_a = '0; tri_ch.index_b = '0; tri_ch.index_c = '0;
        {tri_ch.a_x, tri_ch.a_y, tri_ch.a_z} = '0;
        {tri_ch.b_x, tri_ch.b_y, tri_ch.b_z} = '0;
        {tri_ch.c_x, tri_ch.c_y, tri_ch.c_z} = '0;
        cfg_ch.valid = 0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset plane z = 0
        p = '{0, 0, 32'hffff_0000, 0, 0, 32'h0001_0000, 0, 0, 32'h0002_0000};
        send_tri(IB'(1), IB'(2), IB'(3), p);                 // lone a down
        p = '{0, 0, 32'h0001_0000, 0, 0, 32'hffff_0000, 0, 0, 32'hfffe_0000};
        send_tri(IB'(5), IB'(4), IB'(3), p);                 // lone a up
        p = '{0, 0, 32'h0001_0000, 0, 0, 32'hffff_0000, 0, 0, 32'h0001_0000};
        send_tri(IB'(7), IB'(0), 20'hfffff, p);              // lone b down
        p = '{0, 0, 32'h8000_0000, 0, 0, 32'h7fff_ffff, 0, 0, 32'h8000_0000};
        send_tri(20'hfffff, IB'(0), IB'(9), p);              // lone b up
        p = '{0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000, 0, 0, 32'hffff_ffff};
        send_tri(IB'(3), IB'(9), IB'(1), p);                 // lone c down
        p = '{32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 5, 5, 32'h8000_0000,
              32'h8000_0000, 32'h7fff_ffff, 0};
        send_tri(IB'(2), IB'(11), IB'(6), p);                // lone c up, exactly on plane
        p = '{0, 0, 1, 0, 0, 2, 0, 0, 3};
        send_tri(IB'(1), IB'(2), IB'(3), p);                 // all up
        p = '{0, 0, -1, 0, 0, -2, 0, 0, -3};
        send_tri(IB'(1), IB'(2), IB'(3), p);                 // all down
        p = '{0, 0, 32'hffff_0000, 0, 0, 32'h0001_0000, 0, 0, 32'h0002_0000};
        send_tri(IB'(4), IB'(4), IB'(3), p);                 // repeated index
        send_tri(IB'(4), IB'(3), IB'(3), p);
        send_tri(IB'(3), IB'(4), IB'(3), p);
        drain();

        // extreme plane: large normals amplify distances
        set_plane(32'h0001_ffff, 32'h0002_0000, 32'h0001_ffff, 32'h8000_0000);
        write_reg(tps_pkg::t_reg_idx'(8'd7), 32'hffff_ffff); // unmapped index
        cfg_ch.valid <= 1'b0;
        for (int i = 0; i < 10; i++) send_random_tri();
        drain();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: set_plane(0, 0, 32'h0001_0000, 0);
                1: set_plane($urandom, $urandom, $urandom, $urandom);
                2: set_plane(32'h0002_0000, 32'h0001_ffff, 32'h0002_0000, 32'h7fff_ffff);
                3: set_plane(32'h0000_0001, 0, 32'hffff_ffff, $urandom_range(255));
                default: set_plane($urandom, $urandom, $urandom, 32'($urandom) >>> 8);
            endcase
            cfg_ch.valid <= 1'b0;
            src_busy_free = (phase == 2);
            snk_busy_free = (phase == 2);
            for (int i = 0; i < 240; i++) begin
                if (phase == 1 && i == 60) begin
                    // block fills and stalls while results are held off
                    fork
                        begin
                            snk_hold = 1;
                            repeat (150) @(posedge i_clk);
                            snk_hold = 0;
                        end
                    join_none
                end
                if (phase == 3 && i == 120) begin
                    tri_ch.valid <= 1'b0;
                    do @(posedge i_clk); while (pending != 0);
                end
                send_random_tri();
            end
            drain();
        end

        if (errors == 0)
            $display("triangle_plane_slicer regression: pass");
        else
            $display("triangle_plane_slicer regression: fail");
        $finish;
    end

endmodule
